// ===== design/gjk_simplex_update_macros.svh =====
// Assertion macros shared by the checker.
`ifndef GJK_SIMPLEX_UPDATE_MACROS_SVH
`define GJK_SIMPLEX_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gsu_pkg.sv =====
`timescale 1ns / 1ps
package gsu_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIR_BITS   = 56;

  // Transaction modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ADD   = 1'b1;

  // Query status codes
  localparam logic [1:0] STAT_CONTINUE  = 2'd0;
  localparam logic [1:0] STAT_SEPARATED = 2'd1;
  localparam logic [1:0] STAT_OVERLAP   = 2'd2;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
    logic [2:0]                 point_count;
  } out_t;

endpackage

// ===== design/gjk_simplex_update.sv =====
`timescale 1ns / 1ps
// A start transaction, or an add after the query has finished, shows its result in the
// cycle after acceptance. A live add runs its dot and cross products in turn, all on one
// 33-bit by 17-bit multiplier that takes each product in two halves, low and high.
// One transaction at a time: not ready while one is in flight or its result is stalled.
// Reset (rst, synchronous): empty simplex, zero direction, status continue.
module gjk_simplex_update (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gsu_pkg::out_t out_data
);
  import gsu_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int NB   = CB + 1;
  localparam int UW   = 2 * CB + 3;
  localparam int VW   = 3 * CB + 5;
  localparam int AMAX = (VW > DIR_BITS) ? VW : DIR_BITS;
  localparam int MX   = 33;
  localparam int PW   = MX + NB;
  localparam int AW   = AMAX + NB + 2;
  localparam int SW   = AMAX + 1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_L_DOT = 15'b000000000000100,
    S_L_X1  = 15'b000000000001000,
    S_L_X2  = 15'b000000000010000,
    S_T_UP  = 15'b000000000100000,
    S_T_X1  = 15'b000000001000000,
    S_T_D1  = 15'b000000010000000,
    S_T_D2  = 15'b000000100000000,
    S_T_X3  = 15'b000001000000000,
    S_T_D3  = 15'b000010000000000,
    S_T_D4  = 15'b000100000000000,
    S_Q_X   = 15'b001000000000000,
    S_Q_D   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } step_t;

  typedef enum logic [2:0] {
    SRC_AB, SRC_AC, SRC_AD, SRC_AO, SRC_P, SRC_DIR, SRC_U, SRC_V
  } src_t;

  step_t step;
  logic signed [CB-1:0]       pts [4][3];
  logic signed [CB-1:0]       p [3];
  logic signed [DIR_BITS-1:0] dir [3];
  logic signed [UW-1:0]       u [3];
  logic signed [VW-1:0]       v [3];
  logic [2:0]                 size;
  logic [1:0]                 status;
  logic [1:0]                 qf;
  logic [4:0]                 cnt;
  logic signed [PW-1:0]       prod;
  logic signed [AW-1:0]       acc;

  logic signed [NB-1:0] ab [3];
  logic signed [NB-1:0] ac [3];
  logic signed [NB-1:0] ad [3];
  logic signed [NB-1:0] ao [3];

  logic                   op_cross;
  logic                   dest_v;
  src_t                   a_sel, b_sel;
  logic [4:0]             cnt_last;
  logic [3:0]             term;
  logic                   ph, half, negt, comp_end;
  logic [1:0]             k, ia, ib;
  logic signed [AMAX-1:0] a_op;
  logic signed [NB-1:0]   b_op;
  logic signed [MX-1:0]   mx;
  logic signed [AW-1:0]   pext, pterm, acc_next;
  logic                   dot_pos, dot_neg;
  logic [2:0]             size_grown;

  function automatic logic [1:0] next3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic signed [DIR_BITS-1:0] sat_dir(input logic signed [VW-1:0] x);
    logic signed [SW-1:0] e, hi, lo;
    e  = SW'(x);
    hi = {{(SW-DIR_BITS+1){1'b0}}, {(DIR_BITS-1){1'b1}}};
    lo = ~hi;
    if (e > hi) return DIR_BITS'(hi);
    if (e < lo) return DIR_BITS'(lo);
    return DIR_BITS'(e);
  endfunction

  // Edge vectors from the front point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = NB'(pts[1][i]) - NB'(pts[0][i]);
      ac[i] = NB'(pts[2][i]) - NB'(pts[0][i]);
      ad[i] = NB'(pts[3][i]) - NB'(pts[0][i]);
      ao[i] = -NB'(pts[0][i]);
    end
  end

  // Operation of the current step
  always_comb begin
    op_cross = 1'b0;
    dest_v   = 1'b0;
    a_sel    = SRC_AB;
    b_sel    = SRC_AO;
    unique case (step)
      S_CHECK: begin a_sel = SRC_DIR; b_sel = SRC_P; end
      S_L_DOT: begin a_sel = SRC_AB; end
      S_L_X1:  begin op_cross = 1'b1; a_sel = SRC_AB; end
      S_L_X2:  begin op_cross = 1'b1; dest_v = 1'b1; a_sel = SRC_U; b_sel = SRC_AB; end
      S_T_UP:  begin op_cross = 1'b1; a_sel = SRC_AB; b_sel = SRC_AC; end
      S_T_X1:  begin op_cross = 1'b1; dest_v = 1'b1; a_sel = SRC_U; b_sel = SRC_AC; end
      S_T_D1:  begin a_sel = SRC_V; end
      S_T_D2:  begin a_sel = SRC_AC; end
      S_T_X3:  begin op_cross = 1'b1; dest_v = 1'b1; a_sel = SRC_U; b_sel = SRC_AB; end
      S_T_D3:  begin a_sel = SRC_V; end
      S_T_D4:  begin a_sel = SRC_U; end
      S_Q_X: begin
        op_cross = 1'b1;
        case (qf)
          2'd0:    begin a_sel = SRC_AB; b_sel = SRC_AC; end
          2'd1:    begin a_sel = SRC_AC; b_sel = SRC_AD; end
          default: begin a_sel = SRC_AD; b_sel = SRC_AB; end
        endcase
      end
      S_Q_D:   begin a_sel = SRC_U; end
      S_IDLE, S_DONE: begin end
      default: begin end
    endcase
  end

  // Term decode: cross = 3 components x 2 products x 2 halves, dot = 3 x 2 halves
  always_comb begin
    cnt_last = op_cross ? 5'd24 : 5'd12;
    term     = cnt[4:1];
    ph       = cnt[0];
    half     = term[0];
    if (op_cross) begin
      k        = term[3:2];
      negt     = term[1];
      ia       = term[1] ? next3(next3(k)) : next3(k);
      ib       = term[1] ? next3(k) : next3(next3(k));
      comp_end = ph && term[1] && term[0];
    end else begin
      k        = term[2:1];
      negt     = 1'b0;
      ia       = term[2:1];
      ib       = term[2:1];
      comp_end = 1'b0;
    end
  end

  // Operand selection
  always_comb begin
    case (a_sel)
      SRC_AB:  a_op = AMAX'(ab[ia]);
      SRC_AC:  a_op = AMAX'(ac[ia]);
      SRC_AD:  a_op = AMAX'(ad[ia]);
      SRC_AO:  a_op = AMAX'(ao[ia]);
      SRC_P:   a_op = AMAX'(p[ia]);
      SRC_DIR: a_op = AMAX'(dir[ia]);
      SRC_U:   a_op = AMAX'(u[ia]);
      default: a_op = AMAX'(v[ia]);
    endcase
    case (b_sel)
      SRC_AB:  b_op = ab[ib];
      SRC_AC:  b_op = ac[ib];
      SRC_AD:  b_op = ad[ib];
      SRC_P:   b_op = NB'(p[ib]);
      default: b_op = ao[ib];
    endcase
    mx = half ? MX'($signed(a_op[AMAX-1:32])) : $signed({1'b0, a_op[31:0]});
  end

  // Accumulate the registered partial product
  always_comb begin
    pext     = AW'(prod);
    pterm    = half ? (pext <<< 32) : pext;
    acc_next = negt ? acc - pterm : acc + pterm;
    dot_pos  = !acc[AW-1] && (acc != '0);
    dot_neg  = acc[AW-1];
    size_grown = (size == 3'd4) ? 3'd4 : size + 3'd1;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= S_IDLE;
      size   <= '0;
      status <= STAT_CONTINUE;
      qf     <= '0;
      cnt    <= '0;
      acc    <= '0;
      for (int i = 0; i < 3; i++) begin
        dir[i] <= '0;
        for (int j = 0; j < 4; j++) pts[j][i] <= '0;
      end
    end else begin
      unique case (step)
        S_IDLE: begin
          if (in_valid) begin
            p[0] <= in_data.point_x;
            p[1] <= in_data.point_y;
            p[2] <= in_data.point_z;
            cnt  <= '0;
            acc  <= '0;
            if (in_data.mode == MODE_START || size == 3'd0) begin
              pts[0][0] <= in_data.point_x;
              pts[0][1] <= in_data.point_y;
              pts[0][2] <= in_data.point_z;
              dir[0]    <= -DIR_BITS'(in_data.point_x);
              dir[1]    <= -DIR_BITS'(in_data.point_y);
              dir[2]    <= -DIR_BITS'(in_data.point_z);
              size      <= 3'd1;
              status    <= STAT_CONTINUE;
              step      <= S_DONE;
            end else if (status != STAT_CONTINUE) begin
              step <= S_DONE;
            end else begin
              step <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (out_ready) step <= S_IDLE;
        end
        default: begin
          if (cnt != cnt_last) begin
            // Multiply-accumulate phase
            cnt <= cnt + 5'd1;
            if (!ph) begin
              prod <= mx * b_op;
            end else if (comp_end) begin
              acc <= '0;
              if (dest_v) v[k] <= VW'(acc_next);
              else        u[k] <= UW'(acc_next);
            end else begin
              acc <= acc_next;
            end
          end else begin
            // Decision once the operation is complete
            cnt <= '0;
            acc <= '0;
            case (step)
              S_CHECK: begin
                if (!dot_pos) begin
                  status <= STAT_SEPARATED;
                  step   <= S_DONE;
                end else begin
                  pts[3] <= pts[2];
                  pts[2] <= pts[1];
                  pts[1] <= pts[0];
                  pts[0] <= p;
                  size   <= size_grown;
                  qf     <= '0;
                  case (size_grown)
                    3'd2:    step <= S_L_DOT;
                    3'd3:    step <= S_T_UP;
                    default: step <= S_Q_X;
                  endcase
                end
              end
              S_L_DOT: begin
                if (dot_pos) begin
                  step <= S_L_X1;
                end else begin
                  size <= 3'd1;
                  for (int i = 0; i < 3; i++) dir[i] <= DIR_BITS'(ao[i]);
                  step <= S_DONE;
                end
              end
              S_L_X1: step <= S_L_X2;
              S_L_X2: begin
                for (int i = 0; i < 3; i++) dir[i] <= sat_dir(v[i]);
                step <= S_DONE;
              end
              S_T_UP: step <= S_T_X1;
              S_T_X1: step <= S_T_D1;
              S_T_D1: step <= dot_pos ? S_T_D2 : S_T_X3;
              S_T_D2: begin
                size <= 3'd2;
                if (dot_pos) begin
                  pts[1] <= pts[2];
                  step   <= S_L_X1;
                end else begin
                  step <= S_L_DOT;
                end
              end
              S_T_X3: step <= S_T_D3;
              S_T_D3: begin
                if (dot_neg) begin
                  size <= 3'd2;
                  step <= S_L_DOT;
                end else begin
                  step <= S_T_D4;
                end
              end
              S_T_D4: begin
                if (dot_pos) begin
                  for (int i = 0; i < 3; i++) dir[i] <= DIR_BITS'(u[i]);
                end else begin
                  pts[1] <= pts[2];
                  pts[2] <= pts[1];
                  for (int i = 0; i < 3; i++) dir[i] <= -DIR_BITS'(u[i]);
                end
                step <= S_DONE;
              end
              S_Q_X: step <= S_Q_D;
              S_Q_D: begin
                if (dot_pos) begin
                  // Origin beyond this face: keep it as the triangle
                  size <= 3'd3;
                  case (qf)
                    2'd1: begin pts[1] <= pts[2]; pts[2] <= pts[3]; end
                    2'd2: begin pts[1] <= pts[3]; pts[2] <= pts[1]; end
                    default: begin end
                  endcase
                  step <= S_T_UP;
                end else if (qf == 2'd2) begin
                  status <= STAT_OVERLAP;
                  step   <= S_DONE;
                end else begin
                  qf   <= qf + 2'd1;
                  step <= S_Q_X;
                end
              end
              default: step <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // Result port
  assign in_ready  = (step == S_IDLE);
  assign out_valid = (step == S_DONE);
  always_comb begin
    out_data.status      = status;
    out_data.dir_x       = dir[0];
    out_data.dir_y       = dir[1];
    out_data.dir_z       = dir[2];
    out_data.point_count = size;
  end

endmodule

// ===== design/gsu_checker.sv =====
`timescale 1ns / 1ps
`include "gjk_simplex_update_macros.svh"
module gsu_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input gsu_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input gsu_pkg::out_t out_data
);
  import gsu_pkg::*;

  // Stalled result holds
  `GSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  // One transaction in flight at a time
  `GSU_ASSERT_NOW(a_one_in_flight, in_ready, !out_valid, "ready while a result is pending")
  `GSU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
  // Result contents stay legal
  `GSU_ASSERT_NOW(a_count_range, out_valid, out_data.point_count >= 3'd1 && out_data.point_count <= 3'd4, "bad point count")
  `GSU_ASSERT_NOW(a_status_code, out_valid, out_data.status == STAT_CONTINUE || out_data.status == STAT_SEPARATED || out_data.status == STAT_OVERLAP, "bad status")

endmodule

bind gjk_simplex_update gsu_checker u_gsu_checker (.*);
